>>> sv/zblc_pkg.sv
// Shared constants, types and codes of the lazy-clear depth buffer with cut profile.
`default_nettype none
package zblc_pkg;
   localparam int LINE_COUNT     = 480;
   localparam int LINE_PIXELS    = 640;
   localparam int MAX_CUT_POINTS = 16;
   localparam int INFINITE_DEPTH = 32767;

   localparam int LINE_W  = $clog2(LINE_COUNT);
   localparam int PIX_W   = $clog2(LINE_PIXELS);
   localparam int STORE_N = LINE_COUNT * LINE_PIXELS;
   localparam int STORE_W = $clog2(STORE_N);
   localparam int PT_W    = $clog2(MAX_CUT_POINTS);
   localparam int CNT_W   = PT_W + 1;
   localparam int SWEEP_N = (LINE_COUNT > LINE_PIXELS) ? LINE_COUNT : LINE_PIXELS;
   localparam int SWEEP_W = $clog2(SWEEP_N);

   localparam int ACTION_W = 2;
   localparam int COLUMN_W = 10;
   localparam int ROW_W    = 9;
   localparam int DVAL_W   = 16;
   localparam int STATUS_W = 2;
   localparam int ADDR_W   = 19;
   localparam int DEPTH_W  = 15;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;

   localparam int NUM_W = DVAL_W + 1;
   localparam int Z_W   = DVAL_W + 2;

   typedef enum logic [ACTION_W-1:0] {
      ACT_ACCESS = 2'd0,
      ACT_WRITE  = 2'd1,
      ACT_POINT  = 2'd2,
      ACT_CLEAR  = 2'd3
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_CUT_ERROR = 2'd1,
      ST_RANGE     = 2'd2
   } status_type;

   localparam logic [CSR_IDX_W-1:0] REG_MAX_CUT_COLUMN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_CUT_DEPTH  = 2'd1;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_CHECK,
      S_FILL,
      S_SEG,
      S_DIV,
      S_WALK
   } state_type;
endpackage
`default_nettype wire

>>> sv/zblc_if.sv
// Handshake channels: item request, result and register write.
`default_nettype none
interface zblc_req_if;
   logic                          valid;
   logic                          ready;
   logic [zblc_pkg::ACTION_W-1:0] action;
   logic [zblc_pkg::COLUMN_W-1:0] column;
   logic [zblc_pkg::ROW_W-1:0]    row;
   logic [zblc_pkg::DVAL_W-1:0]   depth_value;
   logic                          last_point;
   modport source (output valid, action, column, row, depth_value, last_point, input ready);
   modport sink (input valid, action, column, row, depth_value, last_point, output ready);
endinterface

interface zblc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [zblc_pkg::STATUS_W-1:0] status;
   logic [zblc_pkg::ADDR_W-1:0]   address;
   logic [zblc_pkg::DEPTH_W-1:0]  stored_depth;
   logic [zblc_pkg::DEPTH_W-1:0]  cut_depth;
   modport source (output valid, status, address, stored_depth, cut_depth, input ready);
   modport sink (input valid, status, address, stored_depth, cut_depth, output ready);
endinterface

interface zblc_csr_if;
   logic                           valid;
   logic                           ready;
   logic [zblc_pkg::CSR_IDX_W-1:0] index;
   logic [zblc_pkg::CSR_DAT_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> sv/zblc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module zblc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 640
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

>>> sv/zblc_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none
module zblc_div (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic signed [zblc_pkg::NUM_W-1:0] num,
   input  wire logic        [zblc_pkg::PIX_W-1:0] den,
   output logic                                   done,
   output logic signed      [zblc_pkg::NUM_W-1:0] quot
);
   import zblc_pkg::*;

   localparam int MAG_W = NUM_W - 1;
   localparam int REM_W = PIX_W + 1;
   localparam int STEP_W = $clog2(MAG_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic             neg_ff, neg_in;
   logic [MAG_W-1:0] mag_ff, mag_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [PIX_W-1:0] den_ff, den_in;
   logic [STEP_W-1:0] step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff  <= neg_in;
      mag_ff  <= mag_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      step_ff <= step_in;
   end

   always_comb begin
      logic [REM_W-1:0] trial;
      logic [NUM_W-1:0] abs_num;
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      mag_in  = mag_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      step_in = step_ff;
      abs_num = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      trial   = {rem_ff[REM_W-2:0], mag_ff[MAG_W-1]};
      if (start) begin
         busy_in = 1'b1;
         neg_in  = num[NUM_W-1];
         mag_in  = abs_num[MAG_W-1:0];
         rem_in  = '0;
         den_in  = den;
         step_in = '0;
      end else if (busy_ff) begin
         if (trial >= REM_W'(den_ff)) begin
            rem_in = trial - REM_W'(den_ff);
            mag_in = {mag_ff[MAG_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            mag_in = {mag_ff[MAG_W-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(MAG_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign done = done_ff;
   assign quot = neg_ff ? -$signed({1'b0, mag_ff}) : $signed({1'b0, mag_ff});
endmodule
`default_nettype wire

>>> sv/zbuffer_lazy_clear_with_cut_profile_unit.sv
// Top level: depth store with lazy per-line fill and cut profile table.
// Access or write on a touched line: S_CHECK loads the result; no item is taken until S_IDLE.
// First touch of a line: S_FILL fills the line through the single depth store write port.
// Last cut point: per rising segment S_SEG starts the divider, S_DIV waits for it and S_WALK
// writes one cut entry per column, x0 to x1; S_SEG skips other segments, then gives the result.
// Clear: S_CLEAR sweeps the touched bits and cut table, then the result.
// Reset: synchronous; the same sweep runs without a result, no item accepted meanwhile.
`default_nettype none
module zbuffer_lazy_clear_with_cut_profile_unit (
   input wire logic clock,
   input wire logic reset,
   zblc_req_if.sink   req_ch,
   zblc_rsp_if.source rsp_ch,
   zblc_csr_if.sink   csr_ch
);
   import zblc_pkg::*;

   state_type state_ff, state_in;
   logic [SWEEP_W-1:0] sweep_ff, sweep_in;
   logic quiet_ff, quiet_in;

   action_type act_ff, act_in;
   logic [COLUMN_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [DVAL_W-1:0] dval_ff, dval_in;
   logic [STORE_W-1:0] addr_ff, addr_in;
   logic [STORE_W-1:0] base_ff, base_in;

   logic [COLUMN_W-1:0] pcol_ff [MAX_CUT_POINTS];
   logic [DVAL_W-1:0] pdep_ff [MAX_CUT_POINTS];
   logic pt_we;
   logic [CNT_W-1:0] pcount_ff, pcount_in;
   logic perr_ff, perr_in;

   logic [CNT_W-1:0] seg_ff, seg_in;
   logic [COLUMN_W-1:0] x0_ff, x0_in;
   logic signed [Z_W-1:0] z0_ff, z0_in;
   logic [COLUMN_W-1:0] j_ff, j_in;
   logic signed [NUM_W-1:0] dz_ff, dz_in;

   logic [COLUMN_W-1:0] max_col_ff;
   logic [DVAL_W-1:0] max_dep_ff;

   logic rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;
   logic [DEPTH_W-1:0] rsp_sd_ff, rsp_sd_in;
   logic [DEPTH_W-1:0] rsp_cd_ff, rsp_cd_in;
   logic rsp_load;

   logic t_we, t_wdata, t_rdata;
   logic [LINE_W-1:0] t_waddr, t_raddr;
   logic c_we;
   logic [PIX_W-1:0] c_waddr, c_raddr;
   logic [DVAL_W-1:0] c_wdata, c_rdata;
   logic d_we;
   logic [STORE_W-1:0] d_waddr, d_raddr;
   logic [DVAL_W-1:0] d_wdata, d_rdata;

   logic div_start, div_done;
   logic signed [NUM_W-1:0] div_num, div_quot;
   logic [PIX_W-1:0] div_den;

   logic accept;
   logic [DEPTH_W-1:0] sat_val;

   zblc_ram #(.WIDTH(1), .DEPTH(LINE_COUNT)) u_touched (
      .clock(clock), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
      .raddr(t_raddr), .rdata(t_rdata)
   );

   zblc_ram #(.WIDTH(DVAL_W), .DEPTH(LINE_PIXELS)) u_cut (
      .clock(clock), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
      .raddr(c_raddr), .rdata(c_rdata)
   );

   zblc_ram #(.WIDTH(DVAL_W), .DEPTH(STORE_N)) u_depth (
      .clock(clock), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
      .raddr(d_raddr), .rdata(d_rdata)
   );

   zblc_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(div_num),
      .den(div_den), .done(div_done), .quot(div_quot)
   );

   assign req_ch.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign accept = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.status = rsp_status_ff;
   assign rsp_ch.address = rsp_addr_ff;
   assign rsp_ch.stored_depth = rsp_sd_ff;
   assign rsp_ch.cut_depth = rsp_cd_ff;

   assign sat_val = (dval_ff > DVAL_W'(INFINITE_DEPTH)) ? DEPTH_W'(INFINITE_DEPTH)
                                                       : dval_ff[DEPTH_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         sweep_ff     <= '0;
         quiet_ff     <= 1'b1;
         pcount_ff    <= '0;
         perr_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         max_col_ff   <= COLUMN_W'(639);
         max_dep_ff   <= DVAL_W'(INFINITE_DEPTH);
      end else begin
         state_ff  <= state_in;
         sweep_ff  <= sweep_in;
         quiet_ff  <= quiet_in;
         pcount_ff <= pcount_in;
         perr_ff   <= perr_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_ch.valid) begin
            unique case (csr_ch.index)
               REG_MAX_CUT_COLUMN: max_col_ff <= csr_ch.data[COLUMN_W-1:0];
               REG_MAX_CUT_DEPTH:  max_dep_ff <= csr_ch.data;
               default: ;
            endcase
         end
      end
      act_ff  <= act_in;
      col_ff  <= col_in;
      row_ff  <= row_in;
      dval_ff <= dval_in;
      addr_ff <= addr_in;
      base_ff <= base_in;
      seg_ff  <= seg_in;
      x0_ff   <= x0_in;
      z0_ff   <= z0_in;
      j_ff    <= j_in;
      dz_ff   <= dz_in;
      if (pt_we) begin
         pcol_ff[pcount_ff[PT_W-1:0]] <= req_ch.column;
         pdep_ff[pcount_ff[PT_W-1:0]] <= req_ch.depth_value;
      end
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_addr_ff   <= rsp_addr_in;
         rsp_sd_ff     <= rsp_sd_in;
         rsp_cd_ff     <= rsp_cd_in;
      end
   end

   always_comb begin
      logic [STORE_W-1:0] base_calc;
      logic in_range;
      logic new_err;
      logic [CNT_W-1:0] new_count;
      logic [COLUMN_W-1:0] x1;
      logic [DVAL_W-1:0] z1;
      state_in  = state_ff;
      sweep_in  = sweep_ff;
      quiet_in  = quiet_ff;
      act_in    = act_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      dval_in   = dval_ff;
      addr_in   = addr_ff;
      base_in   = base_ff;
      pcount_in = pcount_ff;
      perr_in   = perr_ff;
      seg_in    = seg_ff;
      x0_in     = x0_ff;
      z0_in     = z0_ff;
      j_in      = j_ff;
      dz_in     = dz_ff;
      pt_we     = 1'b0;
      rsp_load      = 1'b0;
      rsp_status_in = ST_OK;
      rsp_addr_in   = '0;
      rsp_sd_in     = '0;
      rsp_cd_in     = '0;
      t_we = 1'b0;
      t_waddr = LINE_W'(row_ff);
      t_wdata = 1'b0;
      t_raddr = LINE_W'(req_ch.row);
      c_we = 1'b0;
      c_waddr = PIX_W'(j_ff);
      c_wdata = '0;
      c_raddr = PIX_W'(req_ch.column);
      d_we = 1'b0;
      d_waddr = base_ff + STORE_W'(sweep_ff);
      d_wdata = DVAL_W'(INFINITE_DEPTH);
      div_start = 1'b0;
      div_num = '0;
      div_den = '0;
      base_calc = STORE_W'(req_ch.row) * STORE_W'(LINE_PIXELS);
      d_raddr = base_calc + STORE_W'(req_ch.column);
      in_range = (int'(req_ch.column) < LINE_PIXELS) && (int'(req_ch.row) < LINE_COUNT);
      new_err = perr_ff;
      new_count = pcount_ff;
      x1 = pcol_ff[seg_ff[PT_W-1:0]];
      z1 = pdep_ff[seg_ff[PT_W-1:0]];

      unique case (state_ff)
         S_CLEAR: begin
            if (int'(sweep_ff) < LINE_COUNT) begin
               t_we = 1'b1;
               t_waddr = LINE_W'(sweep_ff);
            end
            if (int'(sweep_ff) < LINE_PIXELS) begin
               c_we = 1'b1;
               c_waddr = PIX_W'(sweep_ff);
            end
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == SWEEP_W'(SWEEP_N - 1)) begin
               state_in = S_IDLE;
               rsp_load = !quiet_ff;
            end
         end
         S_IDLE: begin
            if (accept) begin
               act_in  = action_type'(req_ch.action);
               col_in  = req_ch.column;
               row_in  = req_ch.row;
               dval_in = req_ch.depth_value;
               addr_in = d_raddr;
               base_in = base_calc;
               unique case (action_type'(req_ch.action))
                  ACT_ACCESS, ACT_WRITE: begin
                     if (in_range) begin
                        state_in = S_CHECK;
                     end else begin
                        rsp_load = 1'b1;
                        rsp_status_in = ST_RANGE;
                     end
                  end
                  ACT_POINT: begin
                     if (int'(pcount_ff) < MAX_CUT_POINTS) begin
                        pt_we = 1'b1;
                        new_count = pcount_ff + 1'b1;
                        if (req_ch.column > max_col_ff || req_ch.depth_value > max_dep_ff) begin
                           new_err = 1'b1;
                        end
                     end else begin
                        new_err = 1'b1;
                     end
                     pcount_in = new_count;
                     perr_in = new_err;
                     if (!req_ch.last_point) begin
                        rsp_load = 1'b1;
                     end else if (new_err || new_count == '0) begin
                        rsp_load = 1'b1;
                        rsp_status_in = new_err ? ST_CUT_ERROR : ST_OK;
                        pcount_in = '0;
                        perr_in = 1'b0;
                     end else begin
                        state_in = S_SEG;
                        seg_in = CNT_W'(1);
                        x0_in = pcol_ff[0];
                        z0_in = Z_W'(pdep_ff[0]);
                     end
                  end
                  ACT_CLEAR: begin
                     state_in = S_CLEAR;
                     sweep_in = '0;
                     quiet_in = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         S_CHECK: begin
            rsp_addr_in = ADDR_W'(addr_ff);
            rsp_cd_in = c_rdata[DEPTH_W-1:0];
            rsp_status_in = ST_OK;
            if (!t_rdata) begin
               t_we = 1'b1;
               t_wdata = 1'b1;
               sweep_in = '0;
               state_in = S_FILL;
               rsp_cd_in = c_rdata[DEPTH_W-1:0];
               dz_in = NUM_W'(c_rdata[DEPTH_W-1:0]);
            end else begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
               if (act_ff == ACT_WRITE) begin
                  d_we = 1'b1;
                  d_waddr = addr_ff;
                  d_wdata = DVAL_W'(sat_val);
                  rsp_sd_in = sat_val;
               end else begin
                  rsp_sd_in = d_rdata[DEPTH_W-1:0];
               end
            end
         end
         S_FILL: begin
            d_we = 1'b1;
            if (act_ff == ACT_WRITE && sweep_ff == SWEEP_W'(col_ff)) begin
               d_wdata = DVAL_W'(sat_val);
            end
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == SWEEP_W'(LINE_PIXELS - 1)) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
               rsp_addr_in = ADDR_W'(addr_ff);
               rsp_cd_in = dz_ff[DEPTH_W-1:0];
               rsp_sd_in = (act_ff == ACT_WRITE) ? sat_val : DEPTH_W'(INFINITE_DEPTH);
            end
         end
         S_SEG: begin
            if (seg_ff >= pcount_ff) begin
               rsp_load = 1'b1;
               pcount_in = '0;
               perr_in = 1'b0;
               state_in = S_IDLE;
            end else if (x1 <= x0_ff) begin
               seg_in = seg_ff + 1'b1;
            end else begin
               div_start = 1'b1;
               div_num = NUM_W'($signed({2'b00, z1}) - z0_ff);
               div_den = PIX_W'(x1 - x0_ff);
               j_in = x0_ff;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               dz_in = div_quot;
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            if (int'(j_ff) < LINE_PIXELS) begin
               c_we = 1'b1;
               c_wdata = z0_ff[DVAL_W-1:0];
            end
            z0_in = z0_ff + Z_W'(dz_ff);
            j_in = j_ff + 1'b1;
            if (j_ff == x1) begin
               x0_in = x1;
               z0_in = Z_W'(z1);
               seg_in = seg_ff + 1'b1;
               state_in = S_SEG;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ch.ready |-> state_ff == S_IDLE)
      else $error("ready outside idle");
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || rsp_ch.ready))
      else $error("result overwritten");
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      int'(pcount_ff) <= MAX_CUT_POINTS)
      else $error("point count overflow");
   a_depth_we: assert property (@(posedge clock) disable iff (reset)
      d_we |-> (state_ff == S_FILL || state_ff == S_CHECK))
      else $error("depth write outside fill or check");
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIV)
      else $error("divider finished outside wait");
endmodule
`default_nettype wire
